@@ rtl/core/gsw_pkg.sv @@
`default_nettype none
package gsw_pkg;

    localparam int VERTEX_COUNT   = 16;
    localparam int VW             = 4;   // vertex number width
    localparam int SPW            = $clog2(VERTEX_COUNT + 1);
    localparam int WEIGHT_BITS    = 16;
    localparam int DIST_BITS      = 20;
    localparam int EDGE_SLOTS_DEF = 64;

    typedef enum logic [2:0] {
        OP_ADD_VTX  = 3'd0,
        OP_RM_VTX   = 3'd1,
        OP_ADD_EDGE = 3'd2,
        OP_RM_EDGE  = 3'd3,
        OP_HAS_EDGE = 3'd4,
        OP_HAS_VTX  = 3'd5,
        OP_WALK     = 3'd6,
        OP_PATH     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_MISSING = 3'd1,
        ST_FULL    = 3'd2,
        ST_UNREACH = 3'd3,
        ST_ZERO_WT = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        C_NONE,
        C_LATCH,
        C_ADD_VTX,
        C_HAS_VTX,
        C_ERR_MISSING,
        C_ERR_FULL,
        C_ERR_ZERO,
        C_APPEND,
        C_PURGE_START,
        C_PURGE_STEP,
        C_PURGE_END,
        C_HAS_START,
        C_HAS_STEP,
        C_HAS_END,
        C_WALK_INIT,
        C_WALK_TOP,
        C_WALK_SCAN,
        C_WALK_EMIT,
        C_WALK_END,
        C_PATH_INIT,
        C_SEL_STEP,
        C_PICK,
        C_RELAX_STEP,
        C_UNREACH,
        C_SAME,
        C_BT_INIT,
        C_BT_TOP,
        C_BT_SCAN,
        C_PATH_OUT
    } dp_cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_PURGE,
        S_PURGE_END,
        S_HAS,
        S_HAS_END,
        S_WK_TOP,
        S_WK_SCAN,
        S_WK_EMIT,
        S_WK_END,
        S_PT_SEL,
        S_PT_PICK,
        S_PT_RELAX,
        S_PT_CHECK,
        S_PT_BT_TOP,
        S_PT_BT_SCAN,
        S_PT_OUT
    } ctrl_state_t;

    typedef struct packed {
        op_t  op;
        logic a_present;
        logic both;
        logic w_zero;
        logic full;
        logic scan_busy;
        logic wk_hit;
        logic bt_hit;
        logic sel_last;
        logic u_valid;
        logic sp_zero;
        logic bt_stop;
        logic reached_t;
        logic s_eq_t;
        logic cnt_zero;
        logic cnt_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/core/gsw_ctrl.sv @@
`default_nettype none
module gsw_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  gsw_pkg::dp_status_t   sts,
    output gsw_pkg::dp_cmd_t      cmd
);
    import gsw_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = C_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = C_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.op)
                    OP_ADD_VTX: begin
                        if (sts.out_free) begin
                            cmd        = C_ADD_VTX;
                            state_next = S_IDLE;
                        end
                    end
                    OP_HAS_VTX: begin
                        if (sts.out_free) begin
                            cmd        = C_HAS_VTX;
                            state_next = S_IDLE;
                        end
                    end
                    OP_RM_VTX: begin
                        if (!sts.a_present) begin
                            if (sts.out_free) begin
                                cmd        = C_ERR_MISSING;
                                state_next = S_IDLE;
                            end
                        end else begin
                            cmd        = C_PURGE_START;
                            state_next = S_PURGE;
                        end
                    end
                    OP_ADD_EDGE: begin
                        if (sts.out_free) begin
                            state_next = S_IDLE;
                            priority if (!sts.both) cmd = C_ERR_MISSING;
                            else if (sts.w_zero)    cmd = C_ERR_ZERO;
                            else if (sts.full)      cmd = C_ERR_FULL;
                            else                    cmd = C_APPEND;
                        end
                    end
                    OP_RM_EDGE: begin
                        if (!sts.both) begin
                            if (sts.out_free) begin
                                cmd        = C_ERR_MISSING;
                                state_next = S_IDLE;
                            end
                        end else begin
                            cmd        = C_PURGE_START;
                            state_next = S_PURGE;
                        end
                    end
                    OP_HAS_EDGE: begin
                        if (!sts.both) begin
                            if (sts.out_free) begin
                                cmd        = C_ERR_MISSING;
                                state_next = S_IDLE;
                            end
                        end else begin
                            cmd        = C_HAS_START;
                            state_next = S_HAS;
                        end
                    end
                    OP_WALK: begin
                        if (!sts.a_present) begin
                            if (sts.out_free) begin
                                cmd        = C_ERR_MISSING;
                                state_next = S_IDLE;
                            end
                        end else begin
                            cmd        = C_WALK_INIT;
                            state_next = S_WK_TOP;
                        end
                    end
                    OP_PATH: begin
                        if (!sts.both) begin
                            if (sts.out_free) begin
                                cmd        = C_ERR_MISSING;
                                state_next = S_IDLE;
                            end
                        end else begin
                            cmd        = C_PATH_INIT;
                            state_next = S_PT_SEL;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_PURGE: begin
                cmd = C_PURGE_STEP;
                if (!sts.scan_busy) state_next = S_PURGE_END;
            end
            S_PURGE_END: begin
                if (sts.out_free) begin
                    cmd        = C_PURGE_END;
                    state_next = S_IDLE;
                end
            end
            S_HAS: begin
                cmd = C_HAS_STEP;
                if (!sts.scan_busy) state_next = S_HAS_END;
            end
            S_HAS_END: begin
                if (sts.out_free) begin
                    cmd        = C_HAS_END;
                    state_next = S_IDLE;
                end
            end
            S_WK_TOP: begin
                if (sts.sp_zero) begin
                    state_next = S_WK_END;
                end else begin
                    cmd        = C_WALK_TOP;
                    state_next = S_WK_SCAN;
                end
            end
            S_WK_SCAN: begin
                cmd = C_WALK_SCAN;
                priority if (sts.wk_hit) state_next = S_WK_EMIT;
                else if (!sts.scan_busy) state_next = S_WK_TOP;
                else                     state_next = S_WK_SCAN;
            end
            S_WK_EMIT: begin
                if (sts.out_free) begin
                    cmd        = C_WALK_EMIT;
                    state_next = S_WK_TOP;
                end
            end
            S_WK_END: begin
                if (sts.out_free) begin
                    cmd        = C_WALK_END;
                    state_next = S_IDLE;
                end
            end
            S_PT_SEL: begin
                cmd = C_SEL_STEP;
                if (sts.sel_last) state_next = S_PT_PICK;
            end
            S_PT_PICK: begin
                if (!sts.u_valid) begin
                    state_next = S_PT_CHECK;
                end else begin
                    cmd        = C_PICK;
                    state_next = S_PT_RELAX;
                end
            end
            S_PT_RELAX: begin
                cmd = C_RELAX_STEP;
                if (!sts.scan_busy) state_next = S_PT_SEL;
            end
            S_PT_CHECK: begin
                if (sts.out_free) begin
                    priority if (!sts.reached_t) begin
                        cmd        = C_UNREACH;
                        state_next = S_IDLE;
                    end else if (sts.s_eq_t) begin
                        cmd        = C_SAME;
                        state_next = S_IDLE;
                    end else begin
                        cmd        = C_BT_INIT;
                        state_next = S_PT_BT_TOP;
                    end
                end
            end
            S_PT_BT_TOP: begin
                if (sts.bt_stop) begin
                    state_next = S_PT_OUT;
                end else begin
                    cmd        = C_BT_TOP;
                    state_next = S_PT_BT_SCAN;
                end
            end
            S_PT_BT_SCAN: begin
                cmd = C_BT_SCAN;
                priority if (sts.bt_hit) state_next = S_PT_BT_TOP;
                else if (!sts.scan_busy) state_next = S_PT_OUT;
                else                     state_next = S_PT_BT_SCAN;
            end
            S_PT_OUT: begin
                if (sts.cnt_zero) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd = C_PATH_OUT;
                    if (sts.cnt_last) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/gsw_dp.sv @@
`default_nettype none
module gsw_dp #(
    parameter int EDGE_SLOTS = gsw_pkg::EDGE_SLOTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  gsw_pkg::dp_cmd_t                     cmd,
    output gsw_pkg::dp_status_t                  sts,
    input  wire logic [2:0]                      s_op,
    input  wire logic [gsw_pkg::VW-1:0]          s_vertex_a,
    input  wire logic [gsw_pkg::VW-1:0]          s_vertex_b,
    input  wire logic [gsw_pkg::WEIGHT_BITS-1:0] s_weight,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [2:0]                           m_status,
    output logic                                 m_answer,
    output logic [gsw_pkg::VW-1:0]               m_out_vertex,
    output logic [gsw_pkg::VW-1:0]               m_hop_from,
    output logic [gsw_pkg::VW-1:0]               m_hop_to,
    output logic [gsw_pkg::WEIGHT_BITS-1:0]      m_hop_weight,
    output logic [gsw_pkg::DIST_BITS-1:0]        m_path_length,
    output logic                                 m_last
);
    import gsw_pkg::*;

    localparam int ECW = $clog2(EDGE_SLOTS + 1);
    localparam int EIW = $clog2(EDGE_SLOTS);
    localparam int EDW = 2 * VW + WEIGHT_BITS;
    localparam int VC  = VERTEX_COUNT;
    localparam int DB  = DIST_BITS;

    // latched request
    op_t                    op_reg;
    logic [VW-1:0]          a_reg, b_reg;
    logic [WEIGHT_BITS-1:0] w_reg;

    logic [VC-1:0]          present_reg;
    logic [ECW-1:0]         ec_reg;

    // edge table
    logic [EDW-1:0]         mem [EDGE_SLOTS];
    logic [EDW-1:0]         rdata_reg;
    logic [ECW-1:0]         rd_idx_reg;
    logic [ECW-1:0]         wr_idx_reg;
    logic                   dv_reg;
    logic [EIW-1:0]         didx_reg;
    logic                   any_reg, found_reg;

    // walk
    logic [VC-1:0]          visited_reg;
    logic [VW-1:0]          sv_reg [VC];
    logic [ECW-1:0]         sc_reg [VC];
    logic [SPW-1:0]         sp_reg;
    logic [VW-1:0]          cur_v_reg, pend_reg, fnd_v_reg;
    logic [EIW-1:0]         fnd_i_reg;

    // path
    logic [VC-1:0]          reached_reg, done_reg;
    logic [DB-1:0]          bd_reg [VC];
    logic [VW-1:0]          sel_v_reg, u_reg, v_reg;
    logic [DB-1:0]          ub_reg, bdu_reg, bdv_reg, run_reg;
    logic                   uv_reg;
    logic [SPW-1:0]         cnt_reg;
    logic [VW-1:0]          hop_src_reg [VC];
    logic [VW-1:0]          hop_dst_reg [VC];
    logic [WEIGHT_BITS-1:0] hop_wt_reg [VC];

    logic                   m_valid_reg;
    logic [2:0]             st_reg;
    logic                   ans_reg, last_reg;
    logic [VW-1:0]          ov_reg, hf_reg, ht_reg;
    logic [WEIGHT_BITS-1:0] hw_reg;
    logic [DB-1:0]          pl_reg;

    logic                   is_scan, issue, scan_busy, out_free;
    logic [VW-1:0]          rd_src, rd_dst;
    logic [WEIGHT_BITS-1:0] rd_wt;
    logic [VW-1:0]          bd_addr;
    logic [DB-1:0]          bd_rd;
    logic [DB:0]            nd, bt_sum;
    logic                   drop, wk_hit, bt_hit, cand, better;
    logic [SPW-1:0]         sp_dec, cnt_dec;
    logic [VW-1:0]          spm1, cnti;
    logic [DB:0]            run_sum;
    logic                   mem_we;
    logic [EIW-1:0]         mem_waddr;
    logic [EDW-1:0]         mem_wdata;
    logic                   emit;
    status_t                o_st;
    logic                   o_ans, o_last;
    logic [VW-1:0]          o_ov, o_hf, o_ht;
    logic [WEIGHT_BITS-1:0] o_hw;
    logic [DB-1:0]          o_pl;

    assign rd_src = rdata_reg[EDW-1 -: VW];
    assign rd_dst = rdata_reg[WEIGHT_BITS +: VW];
    assign rd_wt  = rdata_reg[WEIGHT_BITS-1:0];

    assign is_scan = (cmd == C_PURGE_STEP) || (cmd == C_HAS_STEP) || (cmd == C_WALK_SCAN)
                  || (cmd == C_RELAX_STEP) || (cmd == C_BT_SCAN);
    assign issue     = is_scan && (rd_idx_reg < ec_reg);
    assign scan_busy = (rd_idx_reg < ec_reg) || dv_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        unique case (cmd)
            C_RELAX_STEP: bd_addr = rd_dst;
            C_BT_INIT:    bd_addr = b_reg;
            C_BT_SCAN:    bd_addr = rd_src;
            default:      bd_addr = sel_v_reg;
        endcase
    end
    assign bd_rd = bd_reg[bd_addr];

    assign nd      = {1'b0, bdu_reg} + (DB+1)'(rd_wt);
    assign bt_sum  = {1'b0, bd_rd} + (DB+1)'(rd_wt);
    assign drop    = (op_reg == OP_RM_VTX) ? (rd_src == a_reg || rd_dst == a_reg)
                                           : (rd_src == a_reg && rd_dst == b_reg);
    assign wk_hit  = dv_reg && (rd_src == cur_v_reg) && !visited_reg[rd_dst];
    assign bt_hit  = dv_reg && (rd_dst == v_reg) && reached_reg[rd_src]
                  && (bt_sum == {1'b0, bdv_reg});
    assign cand    = reached_reg[sel_v_reg] && !done_reg[sel_v_reg];
    assign better  = !(uv_reg && (sel_v_reg != '0)) || (bd_rd < ub_reg);
    assign sp_dec  = sp_reg - SPW'(1);
    assign cnt_dec = cnt_reg - SPW'(1);
    assign spm1    = sp_dec[VW-1:0];
    assign cnti    = cnt_dec[VW-1:0];
    assign run_sum = {1'b0, run_reg} + (DB+1)'(hop_wt_reg[cnti]);

    always_comb begin
        sts.op        = op_reg;
        sts.a_present = present_reg[a_reg];
        sts.both      = present_reg[a_reg] && present_reg[b_reg];
        sts.w_zero    = (w_reg == '0);
        sts.full      = (ec_reg == ECW'(EDGE_SLOTS));
        sts.scan_busy = scan_busy;
        sts.wk_hit    = wk_hit;
        sts.bt_hit    = bt_hit;
        sts.sel_last  = (sel_v_reg == VW'(VC - 1));
        sts.u_valid   = uv_reg;
        sts.sp_zero   = (sp_reg == '0);
        sts.bt_stop   = (v_reg == a_reg) || (cnt_reg == SPW'(VC));
        sts.reached_t = reached_reg[b_reg];
        sts.s_eq_t    = (a_reg == b_reg);
        sts.cnt_zero  = (cnt_reg == '0);
        sts.cnt_last  = (cnt_reg == SPW'(1));
        sts.out_free  = out_free;
    end

    // single write port: append or compaction
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wr_idx_reg[EIW-1:0];
        mem_wdata = rdata_reg;
        if (cmd == C_APPEND) begin
            mem_we    = 1'b1;
            mem_waddr = ec_reg[EIW-1:0];
            mem_wdata = {a_reg, b_reg, w_reg};
        end else if (cmd == C_PURGE_STEP && dv_reg && !drop) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (issue) rdata_reg <= mem[rd_idx_reg[EIW-1:0]];
    end

    always_comb begin
        emit   = 1'b0;
        o_st   = ST_OK;
        o_ans  = 1'b0;
        o_ov   = '0;
        o_hf   = '0;
        o_ht   = '0;
        o_hw   = '0;
        o_pl   = '0;
        o_last = 1'b1;
        unique case (cmd)
            C_ADD_VTX: begin
                emit  = 1'b1;
                o_ans = !present_reg[a_reg];
            end
            C_HAS_VTX: begin
                emit  = 1'b1;
                o_ans = present_reg[a_reg];
            end
            C_ERR_MISSING: begin
                emit = 1'b1;
                o_st = ST_MISSING;
            end
            C_ERR_FULL: begin
                emit = 1'b1;
                o_st = ST_FULL;
            end
            C_ERR_ZERO: begin
                emit = 1'b1;
                o_st = ST_ZERO_WT;
            end
            C_APPEND: begin
                emit  = 1'b1;
                o_ans = 1'b1;
            end
            C_PURGE_END: begin
                emit  = 1'b1;
                o_ans = (op_reg == OP_RM_VTX) ? 1'b1 : any_reg;
            end
            C_HAS_END: begin
                emit  = 1'b1;
                o_ans = found_reg;
            end
            C_WALK_EMIT: begin
                emit   = 1'b1;
                o_ov   = pend_reg;
                o_last = 1'b0;
            end
            C_WALK_END: begin
                emit = 1'b1;
                o_ov = pend_reg;
            end
            C_UNREACH: begin
                emit = 1'b1;
                o_st = ST_UNREACH;
            end
            C_SAME: emit = 1'b1;
            C_PATH_OUT: begin
                emit   = 1'b1;
                o_hf   = hop_src_reg[cnti];
                o_ht   = hop_dst_reg[cnti];
                o_hw   = hop_wt_reg[cnti];
                o_pl   = run_sum[DB-1:0];
                o_last = (cnt_reg == SPW'(1));
            end
            default: emit = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            ec_reg      <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            dv_reg <= issue;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd == C_ADD_VTX) present_reg[a_reg] <= 1'b1;
            if (cmd == C_PURGE_START && op_reg == OP_RM_VTX) present_reg[a_reg] <= 1'b0;
            if (cmd == C_APPEND) ec_reg <= ec_reg + ECW'(1);
            if (cmd == C_PURGE_END) ec_reg <= wr_idx_reg;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        didx_reg <= rd_idx_reg[EIW-1:0];
        if (issue) rd_idx_reg <= rd_idx_reg + ECW'(1);
        if (emit) begin
            st_reg   <= o_st;
            ans_reg  <= o_ans;
            ov_reg   <= o_ov;
            hf_reg   <= o_hf;
            ht_reg   <= o_ht;
            hw_reg   <= o_hw;
            pl_reg   <= o_pl;
            last_reg <= o_last;
        end
        unique case (cmd)
            C_LATCH: begin
                op_reg <= op_t'(s_op);
                a_reg  <= s_vertex_a;
                b_reg  <= s_vertex_b;
                w_reg  <= s_weight;
            end
            C_PURGE_START: begin
                rd_idx_reg <= '0;
                wr_idx_reg <= '0;
                any_reg    <= 1'b0;
            end
            C_PURGE_STEP: begin
                if (dv_reg) begin
                    if (drop) any_reg <= 1'b1;
                    else      wr_idx_reg <= wr_idx_reg + ECW'(1);
                end
            end
            C_HAS_START: begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
            end
            C_HAS_STEP: begin
                if (dv_reg && rd_src == a_reg && rd_dst == b_reg) found_reg <= 1'b1;
            end
            C_WALK_INIT: begin
                visited_reg <= VC'(1) << a_reg;
                pend_reg    <= a_reg;
                sv_reg[0]   <= a_reg;
                sc_reg[0]   <= '0;
                sp_reg      <= SPW'(1);
            end
            C_WALK_TOP: begin
                rd_idx_reg <= sc_reg[spm1];
                cur_v_reg  <= sv_reg[spm1];
            end
            C_WALK_SCAN: begin
                if (wk_hit) begin
                    fnd_v_reg <= rd_dst;
                    fnd_i_reg <= didx_reg;
                end else if (!scan_busy) begin
                    sp_reg <= sp_dec;
                end
            end
            C_WALK_EMIT: begin
                sc_reg[spm1]           <= ECW'(fnd_i_reg) + ECW'(1);
                visited_reg[fnd_v_reg] <= 1'b1;
                pend_reg               <= fnd_v_reg;
                if (sp_reg < SPW'(VC)) begin
                    sv_reg[sp_reg[VW-1:0]] <= fnd_v_reg;
                    sc_reg[sp_reg[VW-1:0]] <= '0;
                    sp_reg                 <= sp_reg + SPW'(1);
                end
            end
            C_PATH_INIT: begin
                reached_reg   <= VC'(1) << a_reg;
                done_reg      <= '0;
                bd_reg[a_reg] <= '0;
                sel_v_reg     <= '0;
            end
            C_SEL_STEP: begin
                if (cand && better) begin
                    u_reg  <= sel_v_reg;
                    ub_reg <= bd_rd;
                    uv_reg <= 1'b1;
                end else if (sel_v_reg == '0) begin
                    uv_reg <= 1'b0;
                end
                sel_v_reg <= sel_v_reg + VW'(1);
            end
            C_PICK: begin
                done_reg[u_reg] <= 1'b1;
                bdu_reg         <= ub_reg;
                rd_idx_reg      <= '0;
            end
            C_RELAX_STEP: begin
                if (dv_reg && rd_src == u_reg
                    && (!reached_reg[rd_dst] || nd < {1'b0, bd_rd})) begin
                    reached_reg[rd_dst] <= 1'b1;
                    bd_reg[rd_dst]      <= nd[DB-1:0];
                end
            end
            C_BT_INIT: begin
                v_reg   <= b_reg;
                bdv_reg <= bd_rd;
                cnt_reg <= '0;
                run_reg <= '0;
            end
            C_BT_TOP: rd_idx_reg <= '0;
            C_BT_SCAN: begin
                if (bt_hit) begin
                    hop_src_reg[cnt_reg[VW-1:0]] <= rd_src;
                    hop_dst_reg[cnt_reg[VW-1:0]] <= rd_dst;
                    hop_wt_reg[cnt_reg[VW-1:0]]  <= rd_wt;
                    v_reg                        <= rd_src;
                    bdv_reg                      <= bd_rd;
                    cnt_reg                      <= cnt_reg + SPW'(1);
                end
            end
            C_PATH_OUT: begin
                cnt_reg <= cnt_dec;
                run_reg <= run_sum[DB-1:0];
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = st_reg;
    assign m_answer      = ans_reg;
    assign m_out_vertex  = ov_reg;
    assign m_hop_from    = hf_reg;
    assign m_hop_to      = ht_reg;
    assign m_hop_weight  = hw_reg;
    assign m_path_length = pl_reg;
    assign m_last        = last_reg;

endmodule
`default_nettype wire

@@ rtl/core/graph_store_walk_shortest_path.sv @@
// Vertex remove, edge remove and edge test each scan the edge table, which
// gives one read per cycle. Walk: repeated scans of the edge table; path: up to
// V+1 selection sweeps plus V relax scans, then up to V backtrack scans and one
// result per hop. One request in flight at a time. Reset (synchronous, active
// low) empties the vertex set and the edge count; table contents are not cleared,
// no clearing pass.
`default_nettype none
module graph_store_walk_shortest_path #(
    parameter int EDGE_SLOTS = gsw_pkg::EDGE_SLOTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [2:0]                      s_op,
    input  wire logic [gsw_pkg::VW-1:0]          s_vertex_a,
    input  wire logic [gsw_pkg::VW-1:0]          s_vertex_b,
    input  wire logic [gsw_pkg::WEIGHT_BITS-1:0] s_weight,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [2:0]                           m_status,
    output logic                                 m_answer,
    output logic [gsw_pkg::VW-1:0]               m_out_vertex,
    output logic [gsw_pkg::VW-1:0]               m_hop_from,
    output logic [gsw_pkg::VW-1:0]               m_hop_to,
    output logic [gsw_pkg::WEIGHT_BITS-1:0]      m_hop_weight,
    output logic [gsw_pkg::DIST_BITS-1:0]        m_path_length,
    output logic                                 m_last
);
    import gsw_pkg::*;

    // Controller sequences the request; datapath owns the edge table
    // (registered read, compaction on removal), walk stack and distance file.
    dp_cmd_t    cmd;
    dp_status_t sts;

    gsw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // result register in the datapath decouples the two sides: a new request
    // is taken while the last result still waits
    gsw_dp #(
        .EDGE_SLOTS (EDGE_SLOTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_op          (s_op),
        .s_vertex_a    (s_vertex_a),
        .s_vertex_b    (s_vertex_b),
        .s_weight      (s_weight),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_answer      (m_answer),
        .m_out_vertex  (m_out_vertex),
        .m_hop_from    (m_hop_from),
        .m_hop_to      (m_hop_to),
        .m_hop_weight  (m_hop_weight),
        .m_path_length (m_path_length),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

@@ tb/sv/graph_store_walk_shortest_path_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module graph_store_walk_shortest_path_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic [2:0]                      s_op,
    input  wire logic [gsw_pkg::VW-1:0]          s_vertex_a,
    input  wire logic [gsw_pkg::VW-1:0]          s_vertex_b,
    input  wire logic [gsw_pkg::WEIGHT_BITS-1:0] s_weight,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic [2:0]                      m_status,
    input  wire logic                            m_answer,
    input  wire logic [gsw_pkg::VW-1:0]          m_out_vertex,
    input  wire logic [gsw_pkg::VW-1:0]          m_hop_from,
    input  wire logic [gsw_pkg::VW-1:0]          m_hop_to,
    input  wire logic [gsw_pkg::WEIGHT_BITS-1:0] m_hop_weight,
    input  wire logic [gsw_pkg::DIST_BITS-1:0]   m_path_length,
    input  wire logic                            m_last,
    output int                                   fail_count,
    output int                                   pending
);
    import gsw_pkg::*;

    localparam int SLOTS = EDGE_SLOTS_DEF;

    typedef struct packed {
        logic [2:0]             status;
        logic                   answer;
        logic [VW-1:0]          vtx;
        logic [VW-1:0]          hfrom;
        logic [VW-1:0]          hto;
        logic [WEIGHT_BITS-1:0] hwt;
        logic [DIST_BITS-1:0]   plen;
        logic                   last;
    } reply_t;

    reply_t                 replies_due[$];
    logic [VERTEX_COUNT-1:0] have_vtx;
    logic [VW-1:0]          tab_src[SLOTS];
    logic [VW-1:0]          tab_dst[SLOTS];
    logic [WEIGHT_BITS-1:0] tab_wt[SLOTS];
    int                     n_edges;

    function automatic reply_t mk(logic [2:0] st, logic ans, logic lst);
        reply_t r;
        r = '0;
        r.status = st;
        r.answer = ans;
        r.last   = lst;
        return r;
    endfunction

    function automatic void queue_reply(reply_t r);
        replies_due.insert(replies_due.size(), r);
    endfunction

    // mode 0: drop edges touching a; mode 1: drop a->b
    function automatic logic drop_edges(int mode, int a, int b);
        int  w;
        logic any;
        logic hit;
        w = 0;
        any = 1'b0;
        for (int r = 0; r < n_edges; r++) begin
            hit = (mode == 0) ? (tab_src[r] == a || tab_dst[r] == a)
                              : (tab_src[r] == a && tab_dst[r] == b);
            if (hit) begin
                any = 1'b1;
            end else begin
                tab_src[w] = tab_src[r];
                tab_dst[w] = tab_dst[r];
                tab_wt[w]  = tab_wt[r];
                w++;
            end
        end
        n_edges = w;
        return any;
    endfunction

    task automatic predict_walk(int start);
        logic [VERTEX_COUNT-1:0] seen;
        int     stk_v[VERTEX_COUNT];
        int     stk_c[VERTEX_COUNT];
        int     sp;
        int     v;
        int     c;
        logic   pushed;
        reply_t r;
        seen = '0;
        seen[start] = 1'b1;
        r = mk(ST_OK, 1'b0, 1'b0);
        r.vtx = VW'(start);
        queue_reply(r);
        stk_v[0] = start;
        stk_c[0] = 0;
        sp = 1;
        while (sp > 0) begin
            v = stk_v[sp-1];
            pushed = 1'b0;
            for (c = stk_c[sp-1]; c < n_edges; c++) begin
                if (tab_src[c] == v && !seen[tab_dst[c]]) begin
                    stk_c[sp-1] = c + 1;
                    seen[tab_dst[c]] = 1'b1;
                    r = mk(ST_OK, 1'b0, 1'b0);
                    r.vtx = tab_dst[c];
                    queue_reply(r);
                    if (sp < VERTEX_COUNT) begin
                        stk_v[sp] = int'(tab_dst[c]);
                        stk_c[sp] = 0;
                        sp++;
                    end
                    pushed = 1'b1;
                    break;
                end
            end
            if (!pushed) sp--;
        end
        replies_due[replies_due.size() - 1].last = 1'b1;
    endtask

    task automatic predict_path(int s, int t);
        logic [VERTEX_COUNT-1:0] done;
        logic [VERTEX_COUNT-1:0] got;
        longint best_d[VERTEX_COUNT];
        int     hops[VERTEX_COUNT];
        int     cnt;
        int     u;
        int     v;
        int     pick;
        longint nd;
        longint run;
        reply_t r;
        done = '0;
        got = '0;
        for (int i = 0; i < VERTEX_COUNT; i++) best_d[i] = 0;
        got[s] = 1'b1;
        forever begin
            u = VERTEX_COUNT;
            for (int i = 0; i < VERTEX_COUNT; i++)
                if (got[i] && !done[i] && (u == VERTEX_COUNT || best_d[i] < best_d[u]))
                    u = i;
            if (u == VERTEX_COUNT) break;
            done[u] = 1'b1;
            for (int e = 0; e < n_edges; e++) begin
                if (tab_src[e] != u) continue;
                nd = best_d[u] + tab_wt[e];
                if (!got[tab_dst[e]] || nd < best_d[tab_dst[e]]) begin
                    got[tab_dst[e]] = 1'b1;
                    best_d[tab_dst[e]] = nd;
                end
            end
        end
        if (!got[t]) begin
            queue_reply(mk(ST_UNREACH, 1'b0, 1'b1));
            return;
        end
        if (s == t) begin
            queue_reply(mk(ST_OK, 1'b0, 1'b1));
            return;
        end
        cnt = 0;
        v = t;
        while (v != s && cnt < VERTEX_COUNT) begin
            pick = SLOTS;
            for (int e = 0; e < n_edges; e++)
                if (tab_dst[e] == v && got[tab_src[e]] &&
                    best_d[tab_src[e]] + tab_wt[e] == best_d[v]) begin
                    pick = e;
                    break;
                end
            if (pick >= SLOTS) break;
            hops[cnt++] = pick;
            v = int'(tab_src[pick]);
        end
        run = 0;
        while (cnt > 0) begin
            cnt--;
            run += tab_wt[hops[cnt]];
            r = mk(ST_OK, 1'b0, cnt == 0);
            r.hfrom = tab_src[hops[cnt]];
            r.hto   = tab_dst[hops[cnt]];
            r.hwt   = tab_wt[hops[cnt]];
            r.plen  = DIST_BITS'(run);
            queue_reply(r);
        end
    endtask

    task automatic predict_request(op_t op, int a, int b, logic [WEIGHT_BITS-1:0] w);
        logic both;
        both = have_vtx[a] && have_vtx[b];
        case (op)
            OP_ADD_VTX: begin
                queue_reply(mk(ST_OK, !have_vtx[a], 1'b1));
                have_vtx[a] = 1'b1;
            end
            OP_RM_VTX: begin
                if (!have_vtx[a]) begin
                    queue_reply(mk(ST_MISSING, 1'b0, 1'b1));
                end else begin
                    have_vtx[a] = 1'b0;
                    void'(drop_edges(0, a, 0));
                    queue_reply(mk(ST_OK, 1'b1, 1'b1));
                end
            end
            OP_ADD_EDGE: begin
                if (!both) queue_reply(mk(ST_MISSING, 1'b0, 1'b1));
                else if (w == 0) queue_reply(mk(ST_ZERO_WT, 1'b0, 1'b1));
                else if (n_edges >= SLOTS) queue_reply(mk(ST_FULL, 1'b0, 1'b1));
                else begin
                    tab_src[n_edges] = VW'(a);
                    tab_dst[n_edges] = VW'(b);
                    tab_wt[n_edges]  = w;
                    n_edges++;
                    queue_reply(mk(ST_OK, 1'b1, 1'b1));
                end
            end
            OP_RM_EDGE: begin
                if (!both) queue_reply(mk(ST_MISSING, 1'b0, 1'b1));
                else queue_reply(mk(ST_OK, drop_edges(1, a, b), 1'b1));
            end
            OP_HAS_EDGE: begin
                logic found;
                found = 1'b0;
                for (int e = 0; e < n_edges; e++)
                    if (tab_src[e] == a && tab_dst[e] == b) found = 1'b1;
                if (!both) queue_reply(mk(ST_MISSING, 1'b0, 1'b1));
                else queue_reply(mk(ST_OK, found, 1'b1));
            end
            OP_HAS_VTX: queue_reply(mk(ST_OK, have_vtx[a], 1'b1));
            OP_WALK: begin
                if (!have_vtx[a]) queue_reply(mk(ST_MISSING, 1'b0, 1'b1));
                else predict_walk(a);
            end
            default: begin
                if (!both) queue_reply(mk(ST_MISSING, 1'b0, 1'b1));
                else predict_path(a, b);
            end
        endcase
    endtask

    task automatic compare(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        reply_t e;
        if (!aresetn) begin
            have_vtx   = '0;
            n_edges    = 0;
            fail_count = 0;
            replies_due.delete();
        end else begin
            // results first: a request accepted now cannot answer in this cycle
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected result, status %0d", m_status);
                    fail_count++;
                end else begin
                    e = replies_due.pop_front();
                    compare("status", e.status, m_status);
                    compare("answer", e.answer, m_answer);
                    compare("out_vertex", e.vtx, m_out_vertex);
                    compare("hop_from", e.hfrom, m_hop_from);
                    compare("hop_to", e.hto, m_hop_to);
                    compare("hop_weight", e.hwt, m_hop_weight);
                    compare("path_length", e.plen, m_path_length);
                    compare("last", e.last, m_last);
                end
            end
            if (s_valid && s_ready)
                predict_request(op_t'(s_op), int'(s_vertex_a), int'(s_vertex_b), s_weight);
        end
        pending = replies_due.size();
    end

endmodule
`default_nettype wire

@@ tb/sv/graph_store_walk_shortest_path_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module graph_store_walk_shortest_path_tb;
    import gsw_pkg::*;

    localparam longint CYCLE_LIMIT = 10_000_000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [2:0]             s_op;
    logic [VW-1:0]          s_vertex_a;
    logic [VW-1:0]          s_vertex_b;
    logic [WEIGHT_BITS-1:0] s_weight;
    logic                   m_valid;
    logic                   m_ready;
    logic [2:0]             m_status;
    logic                   m_answer;
    logic [VW-1:0]          m_out_vertex;
    logic [VW-1:0]          m_hop_from;
    logic [VW-1:0]          m_hop_to;
    logic [WEIGHT_BITS-1:0] m_hop_weight;
    logic [DIST_BITS-1:0]   m_path_length;
    logic                   m_last;
    int                     fail_count;
    int                     pending;
    int                     send_idle_pct;   // chance of a gap between requests
    int                     recv_stall_pct;  // chance that m_ready drops
    longint                 cycles = 0;

    graph_store_walk_shortest_path dut (.*);

    graph_store_walk_shortest_path_checker chk (.*);

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: slow path queries on a dense graph stay far below this
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("graph_store_walk_shortest_path_tb: FAIL");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it.
    // s_valid stays high when the next request follows straight on.
    task automatic send_request(op_t op, int a, int b, int w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_vertex_a <= VW'(a);
        s_vertex_b <= VW'(b);
        s_weight   <= WEIGHT_BITS'(w);
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly small graphs so that walks and paths go somewhere; the rest noise.
    // Vertex numbers are kept to a window so that edges meet present vertices.
    task automatic random_requests(int count);
        int  pick;
        int  span;
        int  wt;
        for (int i = 0; i < count; i++) begin
            span = (i % 60 < 40) ? 5 : 15;
            pick = $urandom_range(99);
            wt   = ($urandom_range(9) == 0) ? $urandom_range(65535)
                 : ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 40);
            if (pick < 12)
                send_request(OP_ADD_VTX, $urandom_range(span), 0, $urandom);
            else if (pick < 16)
                send_request(OP_RM_VTX, $urandom_range(span), 0, $urandom);
            else if (pick < 44)
                send_request(OP_ADD_EDGE, $urandom_range(span), $urandom_range(span), wt);
            else if (pick < 50)
                send_request(OP_RM_EDGE, $urandom_range(span), $urandom_range(span), wt);
            else if (pick < 58)
                send_request(OP_HAS_EDGE, $urandom_range(span), $urandom_range(span), wt);
            else if (pick < 63)
                send_request(OP_HAS_VTX, $urandom_range(15), 0, $urandom);
            else if (pick < 78)
                send_request(OP_WALK, $urandom_range(span), $urandom_range(15), $urandom);
            else
                send_request(OP_PATH, $urandom_range(span), $urandom_range(span), $urandom);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = OP_ADD_VTX;
        s_vertex_a     = '0;
        s_vertex_b     = '0;
        s_weight       = '0;
        send_idle_pct  = 27;
        recv_stall_pct = 84;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-graph errors, field extremes, every operation
        send_request(OP_WALK, 15, 0, 0);
        send_request(OP_PATH, 0, 15, 0);
        send_request(OP_HAS_VTX, 15, 0, 16'hFFFF);
        send_request(OP_RM_VTX, 0, 0, 0);
        send_request(OP_ADD_VTX, 0, 0, 0);
        send_request(OP_ADD_VTX, 0, 0, 0);           // already present
        send_request(OP_ADD_VTX, 15, 0, 0);
        send_request(OP_ADD_VTX, 7, 0, 0);
        send_request(OP_ADD_EDGE, 0, 3, 5);          // destination absent
        send_request(OP_ADD_EDGE, 0, 15, 0);         // zero weight
        send_request(OP_ADD_EDGE, 0, 15, 16'hFFFF);
        send_request(OP_ADD_EDGE, 0, 7, 16'hFFFF);
        send_request(OP_ADD_EDGE, 7, 15, 16'hFFFF);  // two-hop route, longer than the direct edge
        send_request(OP_ADD_EDGE, 0, 15, 16'hFFFF);  // parallel edge
        send_request(OP_ADD_EDGE, 15, 15, 1);        // self loop
        send_request(OP_PATH, 0, 15, 0);
        send_request(OP_PATH, 15, 0, 0);             // unreachable
        send_request(OP_PATH, 7, 7, 0);              // start equals target
        send_request(OP_WALK, 0, 0, 0);
        send_request(OP_HAS_EDGE, 0, 15, 0);
        send_request(OP_RM_EDGE, 0, 15, 0);
        send_request(OP_HAS_EDGE, 0, 15, 0);
        send_request(OP_RM_EDGE, 0, 15, 0);
        send_request(OP_RM_VTX, 7, 0, 0);
        send_request(OP_WALK, 0, 0, 0);

        // Fill the edge table to exercise the full status
        for (int i = 0; i < 66; i++)
            send_request(OP_ADD_EDGE, 15, 0, $urandom_range(1, 65535));
        send_request(OP_RM_VTX, 15, 0, 0);
        send_request(OP_RM_VTX, 0, 0, 0);

        random_requests(110);
        send_idle_pct  = 84;
        recv_stall_pct = 27;
        random_requests(110);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_requests(117);
        idle_sender();

        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("graph_store_walk_shortest_path_tb: PASS");
        end else begin
            $display("graph_store_walk_shortest_path_tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/gsw_pkg.sv
rtl/core/gsw_ctrl.sv
rtl/core/gsw_dp.sv
rtl/core/graph_store_walk_shortest_path.sv
tb/sv/graph_store_walk_shortest_path_checker.sv
tb/sv/graph_store_walk_shortest_path_tb.sv
